// ----- rtl/mppc_history_decompressor_core_assert.svh -----
// Assertion macros for the MPPC history decompressor core.
// No dependencies; taken in by the files that assert.
`ifndef MPPC_HISTORY_DECOMPRESSOR_CORE_ASSERT_SVH
`define MPPC_HISTORY_DECOMPRESSOR_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MPPC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MPPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mppc_pkg.sv -----
// Shared types and codes for the MPPC history decompressor.
// No dependencies.
package mppc_pkg;

   localparam logic [1:0] OP_DATA  = 2'd0;
   localparam logic [1:0] OP_EMPTY = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  data_byte;
      logic        first_of_packet;
      logic        last_of_packet;
      logic        compressed_flag;
      logic        reset_flag;
      logic        flush_flag;
      logic [12:0] read_address;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic        status;
      logic [12:0] out_offset;
      logic [15:0] out_length;
      logic [7:0]  read_data;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic start_pkt;
      logic append;
      logic step;
      logic copy_rd;
      logic copy_wr;
      logic clear_wr;
      logic rd_issue;
      logic finish;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       first;
      logic       last;
      logic       flush_start;
      logic       open;
      logic       wait_dec;
      logic       step_copy;
      logic       copy_last;
      logic       clear_last;
      logic       out_free;
   } sts_type;

endpackage

// ----- rtl/mppc_ctrl.sv -----
// Sequencing state machine of the MPPC history decompressor.
// Depends on mppc_pkg.
module mppc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mppc_pkg::sts_type sts,
   output mppc_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_APPEND, ST_DECODE, ST_COPY_RD,
      ST_COPY_WR, ST_CLEAR, ST_FINISH, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      boot_ff, boot_in;
   logic      start;

   assign req_ready = (state_ff == ST_IDLE);
   assign start = (sts.op == mppc_pkg::OP_EMPTY) ||
                  ((sts.op == mppc_pkg::OP_DATA) && (sts.first || !sts.open));

   always_comb begin
      state_in = state_ff;
      boot_in  = boot_ff;
      cmd      = '0;
      cmd.accept = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (sts.op) inside
               mppc_pkg::OP_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ST_EMIT;
               end
               mppc_pkg::OP_EMPTY, mppc_pkg::OP_DATA: begin
                  cmd.start_pkt = start;
                  state_in = (start && sts.flush_start) ? ST_CLEAR : ST_APPEND;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_APPEND: begin
            if (sts.op == mppc_pkg::OP_EMPTY) begin
               state_in = ST_FINISH;
            end else begin
               cmd.append = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.wait_dec) begin
               state_in = sts.last ? ST_FINISH : ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               if (sts.step_copy) state_in = ST_COPY_RD;
            end
         end
         ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            state_in    = sts.copy_last ? ST_DECODE : ST_COPY_RD;
         end
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = boot_ff ? ST_IDLE : ST_APPEND;
               boot_in  = 1'b0;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
      end
   end

endmodule

// ----- rtl/mppc_datapath.sv -----
// Bit buffer, token decoder, history memory and result register.
// Depends on mppc_pkg.
module mppc_datapath #(
   parameter int HISTORY_SIZE = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  mppc_pkg::req_type req_payload,
   input  mppc_pkg::cmd_type cmd,
   output mppc_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mppc_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(HISTORY_SIZE);
   localparam int WW = AW + 1;
   localparam int SW = AW + 2;
   localparam logic [SW-1:0] SIZE_S = SW'(HISTORY_SIZE);
   localparam logic [WW-1:0] SIZE_W = WW'(HISTORY_SIZE);
   localparam logic [AW-1:0] LAST_A = AW'(HISTORY_SIZE - 1);

   typedef enum logic [1:0] {PH_TOKEN, PH_LEN_FIRST, PH_LEN_PREFIX, PH_LEN_VALUE} phase_type;

   mppc_pkg::req_type req_ff;
   mppc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [7:0] hist_mem [HISTORY_SIZE];
   logic [7:0] rdata_ff;

   logic [WW-1:0] wo_ff, wo_in, ps_ff, ps_in;
   logic [31:0]   buf_ff, buf_in;
   logic [5:0]    bc_ff, bc_in;
   phase_type     phase_ff, phase_in;
   logic [13:0]   md_ff, md_in;
   logic [3:0]    pr_ff, pr_in;
   logic          err_ff, err_in;
   logic [15:0]   pt_ff, pt_in;
   logic          comp_ff, comp_in;
   logic          open_ff, open_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] src_ff, src_in;
   logic [12:0]   cnt_ff, cnt_in;
   logic          rpt_status_ff, rpt_status_in;
   logic [12:0]   rpt_offset_ff, rpt_offset_in;
   logic [15:0]   rpt_length_ff, rpt_length_in;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   // decoder outputs
   logic [31:0] aligned, vbits;
   logic [5:0]  need, bc_new;
   logic [3:0]  nb;
   logic        dec_lit, dec_md, dec_copy, dec_err;
   logic [7:0]  dec_lit_val;
   logic [13:0] dec_md_val;
   logic [12:0] dec_len;
   phase_type   dec_phase;
   logic [3:0]  dec_pr;

   logic [SW-1:0] md_w, dist_w, src_w, src_f;
   logic          overrun, fin_err;
   logic [WW-1:0] wo_drop, wo_start, len_w;

   assign aligned = buf_ff << (6'd32 - bc_ff);
   assign nb      = 4'd13 - pr_ff;
   assign vbits   = aligned >> (6'd32 - {2'b00, nb});

   always_comb begin
      need        = 6'd1;
      dec_lit     = 1'b0;
      dec_md      = 1'b0;
      dec_copy    = 1'b0;
      dec_err     = 1'b0;
      dec_lit_val = aligned[31:24];
      dec_md_val  = 14'(aligned[27:22]);
      dec_len     = 13'd3;
      dec_phase   = phase_ff;
      dec_pr      = pr_ff;
      unique case (phase_ff)
         PH_TOKEN: begin
            // unknown low bits read as zero; any such guess needs more bits than held
            if (!aligned[31]) begin
               need    = 6'd8;
               dec_lit = 1'b1;
            end else if (!aligned[30]) begin
               need        = 6'd9;
               dec_lit     = 1'b1;
               dec_lit_val = {1'b1, aligned[29:23]};
            end else if (!aligned[29]) begin
               need       = 6'd16;
               dec_md     = 1'b1;
               dec_md_val = 14'(aligned[28:16]) + 14'd320;
               dec_phase  = PH_LEN_FIRST;
            end else if (aligned[28]) begin
               need       = 6'd10;
               dec_md     = 1'b1;
               dec_phase  = PH_LEN_FIRST;
            end else begin
               need       = 6'd12;
               dec_md     = 1'b1;
               dec_md_val = 14'(aligned[27:20]) + 14'd64;
               dec_phase  = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (aligned[31]) begin
               dec_pr    = 4'd11;
               dec_phase = PH_LEN_PREFIX;
            end else begin
               dec_copy  = 1'b1;
               dec_phase = PH_TOKEN;
            end
         end
         PH_LEN_PREFIX: begin
            if (aligned[31]) begin
               dec_pr  = pr_ff - 4'd1;
               dec_err = (pr_ff == 4'd1);
            end else begin
               dec_phase = PH_LEN_VALUE;
            end
         end
         PH_LEN_VALUE: begin
            if (pr_ff == 4'd0 || pr_ff > 4'd11) begin
               need    = 6'd0;
               dec_err = 1'b1;
            end else begin
               need      = {2'b00, nb};
               dec_copy  = 1'b1;
               dec_len   = (13'd1 << nb) | vbits[12:0];
               dec_phase = PH_TOKEN;
            end
         end
         default: need = 6'd1;
      endcase
   end

   assign bc_new  = bc_ff - need;
   assign overrun = (SW'(wo_ff) + SW'(dec_len)) >= SIZE_S;
   assign md_w    = SW'(md_ff);
   assign dist_w  = (md_w >= SIZE_S) ? md_w - SIZE_S : md_w;
   assign src_w   = SW'(wo_ff) + SIZE_S - dist_w;
   assign src_f   = (src_w >= SIZE_S) ? src_w - SIZE_S : src_w;
   assign fin_err = err_ff || (phase_ff != PH_TOKEN) || (buf_ff != 32'd0);
   assign len_w   = wo_ff - ps_ff;
   assign wo_drop = (open_ff && comp_ff) ? ps_ff : wo_ff;
   assign wo_start = (req_ff.reset_flag || req_ff.flush_flag) ? '0 : wo_drop;

   always_comb begin
      wo_in   = wo_ff;   ps_in   = ps_ff;   buf_in = buf_ff; bc_in = bc_ff;
      phase_in = phase_ff; md_in = md_ff;   pr_in  = pr_ff;  err_in = err_ff;
      pt_in   = pt_ff;   comp_in = comp_ff; open_in = open_ff;
      clr_in  = clr_ff;  src_in  = src_ff;  cnt_in = cnt_ff;
      rpt_status_in = rpt_status_ff;
      rpt_offset_in = rpt_offset_ff;
      rpt_length_in = rpt_length_ff;
      rsp_in  = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we = 1'b0;
      mem_wa = wo_ff[AW-1:0];
      mem_wd = dec_lit_val;

      if (cmd.start_pkt) begin
         comp_in = req_ff.compressed_flag;
         if (req_ff.compressed_flag) begin
            wo_in = wo_start;
            ps_in = wo_start;
         end else begin
            wo_in = wo_drop;
         end
         open_in = 1'b1;
         buf_in = '0; bc_in = '0; phase_in = PH_TOKEN; md_in = '0;
         pr_in = 4'd11; err_in = 1'b0; pt_in = '0;
      end

      if (cmd.append) begin
         if (comp_ff) begin
            if (!err_ff && bc_ff <= 6'd24) begin
               buf_in = {buf_ff[23:0], req_ff.data_byte};
               bc_in  = bc_ff + 6'd8;
            end
         end else if (pt_ff != 16'hffff) begin
            pt_in = pt_ff + 16'd1;
         end
      end

      if (cmd.step) begin
         bc_in    = bc_new;
         buf_in   = buf_ff & ~(32'hffff_ffff << bc_new);
         phase_in = dec_phase;
         pr_in    = dec_pr;
         if (dec_md) md_in = dec_md_val;
         if (dec_err) err_in = 1'b1;
         if (dec_lit) begin
            if (wo_ff >= SIZE_W) begin
               err_in = 1'b1;
            end else begin
               mem_we = 1'b1;
               wo_in  = wo_ff + WW'(1);
            end
         end
         if (dec_copy) begin
            if (overrun) begin
               err_in = 1'b1;
            end else begin
               src_in = src_f[AW-1:0];
               cnt_in = dec_len;
            end
         end
      end

      if (cmd.copy_wr) begin
         mem_we = 1'b1;
         mem_wd = rdata_ff;
         wo_in  = wo_ff + WW'(1);
         src_in = (src_ff == LAST_A) ? '0 : src_ff + AW'(1);
         cnt_in = cnt_ff - 13'd1;
      end

      if (cmd.clear_wr) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = 8'd0;
         clr_in = (clr_ff == LAST_A) ? '0 : clr_ff + AW'(1);
      end

      if (cmd.finish) begin
         if (!comp_ff) begin
            rpt_status_in = 1'b0;
            rpt_offset_in = 13'd0;
            rpt_length_in = pt_ff;
         end else begin
            rpt_status_in = fin_err;
            rpt_offset_in = ps_ff[12:0];
            if (fin_err) begin
               rpt_length_in = 16'd0;
               wo_in = ps_ff;
            end else begin
               rpt_length_in = (32'(len_w) > 32'd65535) ? 16'hffff : 16'(len_w);
            end
         end
         open_in = 1'b0;
         buf_in = '0; bc_in = '0; phase_in = PH_TOKEN; md_in = '0;
         pr_in = 4'd11; err_in = 1'b0; pt_in = '0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (req_ff.opcode == mppc_pkg::OP_READ) begin
            rsp_in = '{result_kind: 1'b1, status: 1'b0, out_offset: 13'd0,
                       out_length: 16'd0, read_data: rdata_ff};
         end else begin
            rsp_in = '{result_kind: 1'b0, status: rpt_status_ff,
                       out_offset: rpt_offset_ff, out_length: rpt_length_ff,
                       read_data: 8'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_payload;
      src_ff <= src_in;
      cnt_ff <= cnt_in;
      rpt_status_ff <= rpt_status_in;
      rpt_offset_ff <= rpt_offset_in;
      rpt_length_ff <= rpt_length_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wo_ff <= '0; ps_ff <= '0; buf_ff <= '0; bc_ff <= '0;
         phase_ff <= PH_TOKEN; md_ff <= '0; pr_ff <= 4'd11; err_ff <= 1'b0;
         pt_ff <= '0; comp_ff <= 1'b0; open_ff <= 1'b0; clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wo_ff <= wo_in; ps_ff <= ps_in; buf_ff <= buf_in; bc_ff <= bc_in;
         phase_ff <= phase_in; md_ff <= md_in; pr_ff <= pr_in; err_ff <= err_in;
         pt_ff <= pt_in; comp_ff <= comp_in; open_ff <= open_in; clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // history memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_wa] <= mem_wd;
      if (cmd.copy_rd) begin
         rdata_ff <= hist_mem[src_ff];
      end else if (cmd.rd_issue) begin
         rdata_ff <= hist_mem[AW'(req_ff.read_address)];
      end
   end

   assign sts.op          = req_ff.opcode;
   assign sts.first       = req_ff.first_of_packet;
   assign sts.last        = req_ff.last_of_packet;
   assign sts.flush_start = req_ff.compressed_flag && req_ff.flush_flag;
   assign sts.open        = open_ff;
   assign sts.wait_dec    = err_ff || !comp_ff || (bc_ff < need);
   assign sts.step_copy   = dec_copy && !overrun;
   assign sts.copy_last   = (cnt_ff == 13'd1);
   assign sts.clear_last  = (clr_ff == LAST_A);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/mppc_history_decompressor_core.sv -----
// MPPC history decompressor core: request/response channels on valid/ready.
// Request bytes are decoded one token per cycle while enough bits are held and no
// match copy runs; a match copies history bytes by a read, then a write, on the
// single history memory. A literal byte passes the dispatch, append and decode
// states after acceptance; a packet end adds the finish and emit report states.
// After reset, and on any compressed packet with the flush flag, the history memory
// is swept to zero, one entry per cycle, during which no request is taken. History
// reads register the byte and return it through the result register once free.
// Depends on mppc_pkg, mppc_ctrl, mppc_datapath and the assertion macro header.
`include "mppc_history_decompressor_core_assert.svh"

module mppc_history_decompressor_core #(
   parameter int HISTORY_SIZE = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mppc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mppc_pkg::rsp_type rsp_payload
);

   mppc_pkg::cmd_type cmd;
   mppc_pkg::sts_type sts;
   logic [2:0]        wr_src;

   // controller: sequences dispatch, decode steps, copies, sweep and report
   mppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: bit buffer, decoder, history memory, result register
   mppc_datapath #(
      .HISTORY_SIZE (HISTORY_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // commands that may write the history memory
   assign wr_src = {cmd.clear_wr, cmd.copy_wr, cmd.step};

   // one writer of the history memory per cycle
   `MPPC_ASSERT_SAME(a_one_writer, clock, reset, 1'b1, $onehot0(wr_src), "history write conflict")
   // no request taken while the history is being swept
   `MPPC_ASSERT_SAME(a_sweep_busy, clock, reset, cmd.clear_wr, !req_ready, "request in sweep")
   // a result is only loaded when the output register can take it
   `MPPC_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, sts.out_free, "result register busy")
   // an accepted request keeps the block busy in the next cycle
   `MPPC_ASSERT_NEXT(a_busy_after, clock, reset, cmd.accept, !req_ready, "ready after accept")

endmodule
